@@ rtl/ccoh_pkg.sv @@
// shared types, constants and codes of the column classifier
// no dependencies
package ccoh_pkg;

   localparam int CELL_COUNT_DEF = 4096;
   localparam int Z_BITS_DEF = 8;
   localparam logic [7:0] SAT_COUNT = 8'd255;

   localparam logic [1:0] CLS_UNKNOWN  = 2'd0;
   localparam logic [1:0] CLS_FREE     = 2'd1;
   localparam logic [1:0] CLS_PASSABLE = 2'd2;
   localparam logic [1:0] CLS_OCCUPIED = 2'd3;

   localparam logic [2:0] WHY_INSUFFICIENT = 3'd0;
   localparam logic [2:0] WHY_EMPTY        = 3'd1;
   localparam logic [2:0] WHY_THIN         = 3'd2;
   localparam logic [2:0] WHY_WALL         = 3'd3;
   localparam logic [2:0] WHY_TUNNEL       = 3'd4;
   localparam logic [2:0] WHY_AMBIGUOUS    = 3'd5;

   localparam logic [2:0] REG_MIN_OBS     = 3'd0;
   localparam logic [2:0] REG_SURF_MAX    = 3'd1;
   localparam logic [2:0] REG_WALL_SPAN   = 3'd2;
   localparam logic [2:0] REG_WALL_RATIO  = 3'd3;
   localparam logic [2:0] REG_TUN_BOUNDS  = 3'd4;
   localparam logic [2:0] REG_TUN_RATIO   = 3'd5;
   localparam logic [2:0] REG_HOLD_TICKS  = 3'd6;
   localparam logic [2:0] REG_CONFIRM     = 3'd7;

   // stored cell state: 2+2+2+8+1+32 = 47 bits
   typedef struct packed {
      logic [1:0]  raw;
      logic [1:0]  settled;
      logic [1:0]  pend_cls;
      logic [7:0]  pend_cnt;
      logic        hold_valid;
      logic [31:0] deadline;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   // classified item passed from front to back
   typedef struct packed {
      logic [1:0]  raw;
      logic [2:0]  reason;
      logic [8:0]  conf;
      logic        trav;
      logic [7:0]  span;
      logic [31:0] now;
   } item_type;

endpackage

@@ rtl/ccoh_ram.sv @@
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
module ccoh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/ccoh_front.sv @@
// front part: confidence divider and column classification
// depends on ccoh_pkg
module ccoh_front #(
   parameter int Z_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [7:0]        seen_voxels,
   input  logic [7:0]        filled_voxels,
   input  logic [7:0]        z_low_index,
   input  logic [7:0]        z_high_index,
   input  logic              heights_finite,
   input  logic [31:0]       now_tick,
   input  logic [7:0]        min_seen,
   input  logic [7:0]        surface_span_max,
   input  logic [7:0]        wall_span_min,
   input  logic [8:0]        wall_ratio_min,
   input  logic [15:0]       tunnel_span_bounds,
   input  logic [8:0]        tunnel_ratio_max,
   output logic              item_valid,
   output ccoh_pkg::item_type item_data,
   input  logic              item_room
);
   import ccoh_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_type;

   localparam logic [7:0] ZMASK = 8'((1 << Z_BITS) - 1);

   state_type   state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [7:0]  mo_ff, mo_in;
   logic [7:0]  obs_ff, occ_ff, lo_ff, hi_ff;
   logic        fin_ff;
   logic [31:0] now_ff;
   logic [7:0]  surf_ff, wspan_ff, tmin_ff, tmax_ff;
   logic [8:0]  wrat_ff, trat_ff;
   item_type    item_comb;
   logic [16:0] rem_sh;
   logic [7:0]  span, filled;
   logic [16:0] lhs, wrhs, trhs;
   logic [8:0]  conf;

   assign busy = (state_ff != ST_IDLE);
   assign item_valid = (state_ff == ST_OUT);
   assign rem_sh = {rem_ff[15:0], 1'b0};

   // restoring division of obs*256 by min_seen (1 when it is zero), one bit a cycle
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      mo_in = mo_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIV;
               cnt_in = 5'd16;
               rem_in = '0;
               quo_in = {seen_voxels, 8'd0};
               mo_in = (min_seen == 8'd0) ? 8'd1 : min_seen;
            end
         end
         ST_DIV: begin
            if ((rem_sh | 17'(quo_ff[15])) >= {9'd0, mo_ff}) begin
               rem_in = (rem_sh | 17'(quo_ff[15])) - {9'd0, mo_ff};
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh | 17'(quo_ff[15]);
               quo_in = {quo_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (item_room) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mo_ff <= mo_in;
      if (state_ff == ST_IDLE && start) begin
         obs_ff <= seen_voxels;
         occ_ff <= filled_voxels;
         lo_ff <= z_low_index & ZMASK;
         hi_ff <= z_high_index & ZMASK;
         fin_ff <= heights_finite;
         now_ff <= now_tick;
         surf_ff <= surface_span_max;
         wspan_ff <= wall_span_min;
         wrat_ff <= wall_ratio_min;
         tmin_ff <= tunnel_span_bounds[7:0];
         tmax_ff <= tunnel_span_bounds[15:8];
         trat_ff <= tunnel_ratio_max;
      end
   end

   // classification on the captured column
   always_comb begin
      span = hi_ff - lo_ff;
      filled = ((occ_ff - 8'd1) > span) ? span : (occ_ff - 8'd1);
      lhs = {1'b0, filled, 8'd0};
      wrhs = {8'd0, wrat_ff} * {9'd0, span};
      trhs = {8'd0, trat_ff} * {9'd0, span};
      conf = (quo_ff > 16'd256) ? 9'd256 : quo_ff[8:0];
      item_comb.conf = conf;
      item_comb.now = now_ff;
      item_comb.span = 8'd0;
      if (obs_ff < mo_ff) begin
         item_comb.raw = CLS_UNKNOWN;
         item_comb.reason = WHY_INSUFFICIENT;
         item_comb.trav = 1'b0;
      end else if (occ_ff == 8'd0) begin
         item_comb.raw = CLS_FREE;
         item_comb.reason = WHY_EMPTY;
         item_comb.trav = 1'b1;
      end else if (lo_ff > hi_ff || !fin_ff) begin
         item_comb.raw = CLS_OCCUPIED;
         item_comb.reason = WHY_AMBIGUOUS;
         item_comb.trav = 1'b0;
      end else begin
         item_comb.span = span;
         if (span <= surf_ff) begin
            item_comb.raw = CLS_PASSABLE;
            item_comb.reason = WHY_THIN;
            item_comb.trav = 1'b1;
         end else if (span >= wspan_ff && lhs >= wrhs) begin
            item_comb.raw = CLS_OCCUPIED;
            item_comb.reason = WHY_WALL;
            item_comb.trav = 1'b0;
         end else if (span >= tmin_ff && span <= tmax_ff && lhs <= trhs) begin
            item_comb.raw = CLS_PASSABLE;
            item_comb.reason = WHY_TUNNEL;
            item_comb.trav = 1'b1;
         end else begin
            item_comb.raw = CLS_OCCUPIED;
            item_comb.reason = WHY_AMBIGUOUS;
            item_comb.trav = 1'b0;
         end
      end
   end

   assign item_data = item_comb;
endmodule

@@ rtl/ccoh_queue.sv @@
// two-entry queue between front and back parts
// depends on ccoh_pkg
module ccoh_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ccoh_pkg::item_type push_item,
   input  logic [11:0]        push_idx,
   output logic               room,
   input  logic               pop,
   output logic               avail,
   output ccoh_pkg::item_type pop_item,
   output logic [11:0]        pop_idx
);
   import ccoh_pkg::*;

   item_type    item_ff [2];
   logic [11:0] idx_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;

   assign room = (cnt_ff != 2'd2);
   assign avail = (cnt_ff != 2'd0);
   assign pop_item = item_ff[rp_ff];
   assign pop_idx = idx_ff[rp_ff];

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && room) wp_ff <= ~wp_ff;
         if (pop && avail) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push && room) - 2'(pop && avail);
      end
      if (push && room) begin
         item_ff[wp_ff] <= push_item;
         idx_ff[wp_ff] <= push_idx;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |=> (cnt_ff <= 2'd1)) else $error("queue count jumped");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2) else $error("queue lost entry");
`endif
endmodule

@@ rtl/ccoh_back.sv @@
// back part: cell store clearing, read-modify-write and hold/hysteresis
// depends on ccoh_pkg, ccoh_ram
module ccoh_back #(
   parameter int CELL_COUNT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               avail,
   input  ccoh_pkg::item_type item,
   input  logic [11:0]        cell_index,
   output logic               pop,
   output logic               clearing,
   input  logic [31:0]        hold_ticks,
   input  logic [7:0]         confirm_count,
   output logic               rsp_valid,
   output logic [1:0]         rsp_raw_class,
   output logic [2:0]         rsp_reason,
   output logic [8:0]         rsp_confidence_q8,
   output logic               rsp_raw_traversable,
   output logic [7:0]         rsp_z_span,
   output logic [1:0]         rsp_settled_class,
   output logic               rsp_hold_on
);
   import ccoh_pkg::*;

   localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int DEPTH = (CELL_COUNT > 1) ? CELL_COUNT : 2;

   typedef enum logic [1:0] {ST_CLEAR, ST_READ, ST_WRITE} state_type;

   state_type   state_ff;
   logic [AW:0] clr_ff;
   logic [AW-1:0] addr;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   cell_type    rd_cell, new_cell;
   logic [CELL_W-1:0] rd_bits;
   logic [32:0] dsum;
   logic [31:0] dl;
   logic [7:0]  pc;

   // cell_index arrives already wrapped below CELL_COUNT
   assign addr = AW'(cell_index);
   assign rd_cell = cell_type'(rd_bits);
   assign clearing = (state_ff == ST_CLEAR);
   assign pop = (state_ff == ST_WRITE);
   assign wr_en = clearing || pop;
   assign wr_addr = clearing ? clr_ff[AW-1:0] : addr;

   ccoh_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data(clearing ? '0 : CELL_W'(new_cell)),
      .rd_addr(addr), .rd_data(rd_bits)
   );

   // cell update rules
   always_comb begin
      new_cell = rd_cell;
      dsum = {1'b0, item.now} + {1'b0, hold_ticks};
      dl = rd_cell.hold_valid ? rd_cell.deadline : (dsum[32] ? '1 : dsum[31:0]);
      pc = 8'd0;
      if (item.raw == CLS_OCCUPIED) begin
         new_cell.settled = CLS_OCCUPIED;
         new_cell.hold_valid = 1'b0;
         new_cell.deadline = '0;
         new_cell.pend_cls = CLS_OCCUPIED;
         new_cell.pend_cnt = 8'd0;
      end else if (hold_ticks != 32'd0 &&
                   (rd_cell.raw == CLS_OCCUPIED || rd_cell.hold_valid)) begin
         new_cell.pend_cls = item.raw;
         new_cell.pend_cnt = 8'd0;
         if (item.now < dl) begin
            new_cell.settled = CLS_OCCUPIED;
            new_cell.hold_valid = 1'b1;
            new_cell.deadline = dl;
         end else begin
            new_cell.settled = item.raw;
            new_cell.hold_valid = 1'b0;
            new_cell.deadline = '0;
         end
      end else begin
         new_cell.hold_valid = 1'b0;
         new_cell.deadline = '0;
         if (confirm_count == 8'd0 || rd_cell.settled == CLS_UNKNOWN ||
             item.raw == rd_cell.settled || rd_cell.settled != CLS_OCCUPIED) begin
            new_cell.settled = item.raw;
            new_cell.pend_cls = item.raw;
            new_cell.pend_cnt = 8'd0;
         end else begin
            // settled occupied, counting repeats of a clearer class
            if (rd_cell.pend_cls != item.raw) begin
               pc = 8'd1;
            end else if (rd_cell.pend_cnt < SAT_COUNT) begin
               pc = rd_cell.pend_cnt + 8'd1;
            end else begin
               pc = rd_cell.pend_cnt;
            end
            new_cell.pend_cls = item.raw;
            if (pc >= confirm_count) begin
               new_cell.settled = item.raw;
               new_cell.pend_cnt = 8'd0;
            end else begin
               new_cell.pend_cnt = pc;
            end
         end
      end
      new_cell.raw = item.raw;
   end

   // sequencer and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AW+1)'(CELL_COUNT - 1)) state_ff <= ST_READ;
            end
            ST_READ: begin
               if (avail) state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               state_ff <= ST_READ;
               rsp_valid <= 1'b1;
            end
            default: state_ff <= ST_READ;
         endcase
      end
      if (state_ff == ST_WRITE) begin
         rsp_raw_class <= item.raw;
         rsp_reason <= item.reason;
         rsp_confidence_q8 <= item.conf;
         rsp_raw_traversable <= item.trav;
         rsp_z_span <= item.span;
         rsp_settled_class <= new_cell.settled;
         rsp_hold_on <= new_cell.hold_valid;
      end
   end

`ifndef ASSERT_OFF
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      pop |-> $past(state_ff == ST_READ && avail)) else $error("write without read");
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid) else $error("result missing");
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid) else $error("result during clear");
`endif
endmodule

@@ rtl/column_classifier_with_obstacle_hold.sv @@
// top level of the column classifier with obstacle hold
// depends on ccoh_pkg, ccoh_front, ccoh_queue, ccoh_back
// A command is taken when start is high and busy is low; its result appears
// on the rsp_ ports for one cycle with rsp_valid. The front computes the
// confidence with a bit-serial divider and then classifies, and takes no new
// command until its item has entered the queue; the back does the cell
// read-modify-write in a read state and a write state, fed through a two-entry
// queue. After reset the cell store is swept to unknown, one cell a cycle,
// with busy high. Results cannot be held off by the receiver.
module column_classifier_with_obstacle_hold #(
   parameter int CELL_COUNT = ccoh_pkg::CELL_COUNT_DEF,
   parameter int Z_BITS = ccoh_pkg::Z_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_cell_index,
   input  logic [7:0]  req_seen_voxels,
   input  logic [7:0]  req_filled_voxels,
   input  logic [7:0]  req_z_low_index,
   input  logic [7:0]  req_z_high_index,
   input  logic        req_heights_finite,
   input  logic [31:0] req_now_tick,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_raw_class,
   output logic [2:0]  rsp_reason,
   output logic [8:0]  rsp_confidence_q8,
   output logic        rsp_raw_traversable,
   output logic [7:0]  rsp_z_span,
   output logic [1:0]  rsp_settled_class,
   output logic        rsp_hold_on
);
   import ccoh_pkg::*;

   localparam int IDX_SHIFT = 12 + $clog2(CELL_COUNT);
   localparam longint IDX_MUL =
      ((longint'(1) << IDX_SHIFT) + longint'(CELL_COUNT) - 1) / longint'(CELL_COUNT);

   logic [7:0]  min_obs_ff, surf_ff, wspan_ff, confirm_ff;
   logic [8:0]  wrat_ff, trat_ff;
   logic [15:0] tb_ff;
   logic [31:0] hold_ff;
   logic [11:0] idx_ff, idx_quo_ff, cell_ff;
   logic [31:0] idx_prod;
   logic        front_busy, item_valid, room, avail, pop, clearing;
   item_type    f_item, q_item;
   logic [11:0] q_idx;

   assign busy = front_busy || clearing;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_obs_ff <= 8'd1;
         surf_ff <= 8'd1;
         wspan_ff <= 8'd10;
         wrat_ff <= 9'd200;
         tb_ff <= 16'hFF00;
         trat_ff <= 9'd64;
         hold_ff <= 32'd0;
         confirm_ff <= 8'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_OBS:    min_obs_ff <= csr_data[7:0];
            REG_SURF_MAX:   surf_ff <= csr_data[7:0];
            REG_WALL_SPAN:  wspan_ff <= csr_data[7:0];
            REG_WALL_RATIO: wrat_ff <= csr_data[8:0];
            REG_TUN_BOUNDS: tb_ff <= csr_data[15:0];
            REG_TUN_RATIO:  trat_ff <= csr_data[8:0];
            REG_HOLD_TICKS: hold_ff <= csr_data;
            REG_CONFIRM:    confirm_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // cell index rides alongside the front, wrapped modulo CELL_COUNT by a reciprocal
   // multiply via idx_quo_ff and cell_ff, long settled before the front is done
   assign idx_prod = {20'd0, idx_ff} * 32'(IDX_MUL);

   always_ff @(posedge clock) begin
      if (start && !busy) idx_ff <= req_cell_index;
      idx_quo_ff <= 12'(idx_prod >> IDX_SHIFT);
      cell_ff <= idx_ff - 12'(32'(idx_quo_ff) * 32'(CELL_COUNT));
   end

   ccoh_front #(.Z_BITS(Z_BITS)) u_front (
      .clock(clock), .reset(reset), .start(start && !clearing), .busy(front_busy),
      .seen_voxels(req_seen_voxels), .filled_voxels(req_filled_voxels),
      .z_low_index(req_z_low_index), .z_high_index(req_z_high_index),
      .heights_finite(req_heights_finite), .now_tick(req_now_tick),
      .min_seen(min_obs_ff), .surface_span_max(surf_ff),
      .wall_span_min(wspan_ff), .wall_ratio_min(wrat_ff),
      .tunnel_span_bounds(tb_ff), .tunnel_ratio_max(trat_ff),
      .item_valid(item_valid), .item_data(f_item), .item_room(room)
   );

   ccoh_queue u_queue (
      .clock(clock), .reset(reset), .push(item_valid), .push_item(f_item),
      .push_idx(cell_ff), .room(room), .pop(pop), .avail(avail),
      .pop_item(q_item), .pop_idx(q_idx)
   );

   ccoh_back #(.CELL_COUNT(CELL_COUNT)) u_back (
      .clock(clock), .reset(reset), .avail(avail), .item(q_item),
      .cell_index(q_idx), .pop(pop), .clearing(clearing),
      .hold_ticks(hold_ff), .confirm_count(confirm_ff),
      .rsp_valid(rsp_valid), .rsp_raw_class(rsp_raw_class),
      .rsp_reason(rsp_reason), .rsp_confidence_q8(rsp_confidence_q8),
      .rsp_raw_traversable(rsp_raw_traversable), .rsp_z_span(rsp_z_span),
      .rsp_settled_class(rsp_settled_class), .rsp_hold_on(rsp_hold_on)
   );

`ifndef ASSERT_OFF
   a_no_start_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy) else $error("idle during clear");
   a_rsp_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept did not raise busy");
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid) else $error("result while clearing");
`endif
endmodule
